/* sv/rid_pkg.sv */
// ----------------------------------------------------------------------------
// rid_pkg
// Shared types and codes for the recycling handle allocator: request and
// response payloads, operation and status codes, memory command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rid_pkg;

    // default slot table size and handle/counter widths
    localparam int CAPACITY_DEF = 256;
    localparam int HANDLE_W     = 8;
    localparam int CNT_W        = 9;

    // operation codes
    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]          operation;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] result_handle;
        logic [1:0]          status;
        logic                occupied;
    } rsp_t;

    // controller to memory commands
    typedef struct packed {
        logic                rd_en;
        logic [HANDLE_W-1:0] stack_raddr;
        logic [HANDLE_W-1:0] busy_raddr;
        logic                stack_we;
        logic [HANDLE_W-1:0] stack_waddr;
        logic [HANDLE_W-1:0] stack_wdata;
        logic                busy_we;
        logic [HANDLE_W-1:0] busy_waddr;
        logic                busy_wdata;
    } mem_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

`default_nettype wire

/* sv/rid_store.sv */
// ----------------------------------------------------------------------------
// rid_store
// Free handle stack and slot occupancy bitmap, each a synchronous memory
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rid_store
    import rid_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF
)
(
    input  wire logic                clk,
    input  wire mem_cmd_t            cmd,
    output logic [HANDLE_W-1:0]      stack_rdata,
    output logic                     busy_rdata
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [HANDLE_W-1:0] stack_mem [DEPTH];
    logic                busy_mem  [DEPTH];
    logic [HANDLE_W-1:0] stack_rdata_reg;
    logic                busy_rdata_reg;

    // free handle stack
    always_ff @(posedge clk)
    begin
        if (cmd.stack_we)
        begin
            stack_mem[cmd.stack_waddr[ADDR_W-1:0]] <= cmd.stack_wdata;
        end
        if (cmd.rd_en)
        begin
            stack_rdata_reg <= stack_mem[cmd.stack_raddr[ADDR_W-1:0]];
        end
    end

    // occupancy bitmap, entries at or above the high-water mark are masked by the controller
    always_ff @(posedge clk)
    begin
        if (cmd.busy_we)
        begin
            busy_mem[cmd.busy_waddr[ADDR_W-1:0]] <= cmd.busy_wdata;
        end
        if (cmd.rd_en)
        begin
            busy_rdata_reg <= busy_mem[cmd.busy_raddr[ADDR_W-1:0]];
        end
    end

    assign stack_rdata = stack_rdata_reg;
    assign busy_rdata  = busy_rdata_reg;

endmodule

`default_nettype wire

/* sv/rid_ctrl.sv */
// ----------------------------------------------------------------------------
// rid_ctrl
// Request sequencer: issues memory reads on a request transfer, then
// decides the operation from the read data, writes back the stack and
// bitmap, updates the counters and loads the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rid_ctrl
    import rid_pkg::*;
#(
    parameter int LIMIT = CAPACITY_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire req_t                req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output rsp_t                     rsp,
    output mem_cmd_t                 cmd,
    input  wire logic [HANDLE_W-1:0] stack_rdata,
    input  wire logic                busy_rdata
);

    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

    state_t           state_reg, state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] hw_reg, hw_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;
    logic             accept;
    logic             commit;
    logic [CNT_W-1:0] depth_dec;
    logic             busy_hit;
    logic             handle_ok;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            S_IDLE: req_ready = 1'b1;
            S_EXEC: commit    = !rsp_valid_reg || rsp_ready;
            default:
            begin
                req_ready = 1'b0;
                commit    = 1'b0;
            end
        endcase
    end

    assign accept    = req_valid && req_ready;
    assign depth_dec = depth_reg - CNT_W'(1);

    // slot is occupied only below the high-water mark
    assign busy_hit  = ({1'b0, req_reg.handle} < hw_reg) && busy_rdata;
    assign handle_ok = (req_reg.handle != '0) && ({1'b0, req_reg.handle} < LIMIT_C);

    // operation decode and write-back
    always_comb
    begin
        cmd             = '0;
        cmd.rd_en       = accept;
        cmd.stack_raddr = depth_dec[HANDLE_W-1:0];
        cmd.busy_raddr  = req.handle;
        depth_next      = depth_reg;
        hw_next         = hw_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;

        if (commit)
        begin
            rsp_valid_next = 1'b1;
            case (req_reg.operation)
                OP_CREATE:
                begin
                    if (depth_reg != '0)
                    begin
                        depth_next     = depth_dec;
                        cmd.busy_we    = 1'b1;
                        cmd.busy_waddr = stack_rdata;
                        cmd.busy_wdata = 1'b1;
                        rsp_next       = '{result_handle: stack_rdata, status: ST_OK,
                                           occupied: 1'b1};
                    end
                    else if (hw_reg < LIMIT_C)
                    begin
                        hw_next        = hw_reg + CNT_W'(1);
                        cmd.busy_we    = 1'b1;
                        cmd.busy_waddr = hw_reg[HANDLE_W-1:0];
                        cmd.busy_wdata = 1'b1;
                        rsp_next       = '{result_handle: hw_reg[HANDLE_W-1:0], status: ST_OK,
                                           occupied: 1'b1};
                    end
                    else
                    begin
                        rsp_next = '{result_handle: '0, status: ST_FULL, occupied: 1'b0};
                    end
                end
                OP_DESTROY:
                begin
                    if (handle_ok && busy_hit)
                    begin
                        cmd.busy_we    = 1'b1;
                        cmd.busy_waddr = req_reg.handle;
                        cmd.busy_wdata = 1'b0;
                        // push guard, the stack never really fills
                        if (depth_reg < LIMIT_C)
                        begin
                            cmd.stack_we    = 1'b1;
                            cmd.stack_waddr = depth_reg[HANDLE_W-1:0];
                            cmd.stack_wdata = req_reg.handle;
                            depth_next      = depth_reg + CNT_W'(1);
                        end
                        rsp_next = '{result_handle: req_reg.handle, status: ST_OK,
                                     occupied: 1'b0};
                    end
                    else
                    begin
                        rsp_next = '{result_handle: req_reg.handle, status: ST_BAD,
                                     occupied: 1'b0};
                    end
                end
                default:
                begin
                    // query, unused code behaves the same
                    if (handle_ok && busy_hit)
                    begin
                        rsp_next = '{result_handle: req_reg.handle, status: ST_OK,
                                     occupied: 1'b1};
                    end
                    else
                    begin
                        rsp_next = '{result_handle: req_reg.handle, status: ST_BAD,
                                     occupied: 1'b0};
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            hw_reg        <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            hw_reg        <= hw_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* sv/recycling_id_allocator.sv */
// ----------------------------------------------------------------------------
// recycling_id_allocator
// LIFO free-list handle allocator: create, destroy and query of handles in
// a table of slots, handle zero reserved.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_ready  req_t  (operation, handle)
//   rsp      out  rsp_valid / rsp_ready  rsp_t  (result_handle, status, occupied)
//
// Each request first reads the stack top and the occupancy bit from the
// memories, then writes back and loads the response register.
// A new request is taken as soon as the previous one has left its exec
// state, while its response still waits in the output register.
// A stalled response holds the request in exec until the register frees up.
// Reset clears the counters only; no clearing pass over the memories.
// ----------------------------------------------------------------------------
`default_nettype none

module recycling_id_allocator
    import rid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    // usable handles are 1 .. LIMIT-1
    localparam int LIMIT = (CAPACITY < 256) ? CAPACITY : 256;

    mem_cmd_t            cmd;
    logic [HANDLE_W-1:0] stack_rdata;
    logic                busy_rdata;

    // sequencer
    rid_ctrl #(
        .LIMIT (LIMIT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cmd         (cmd),
        .stack_rdata (stack_rdata),
        .busy_rdata  (busy_rdata)
    );

    // stack and bitmap memories
    rid_store #(
        .DEPTH (LIMIT)
    ) u_store (
        .clk         (clk),
        .cmd         (cmd),
        .stack_rdata (stack_rdata),
        .busy_rdata  (busy_rdata)
    );

endmodule

`default_nettype wire

/* sv/rid_checker.sv */
// ----------------------------------------------------------------------------
// rid_checker
// Port-level checks for the handle allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rid_checker
    import rid_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one request in flight at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in exec");

    // a new response follows a request transfer, through the exec state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without a request");

    // full reports no handle and no occupancy
    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.result_handle == '0 && !rsp.occupied)
        else $error("full response carries a handle");

    // an occupied slot is never handle zero and never a failed request
    a_occ_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.occupied |-> rsp.status == ST_OK && rsp.result_handle != '0)
        else $error("occupied reported for a bad handle");

endmodule

bind recycling_id_allocator rid_checker u_rid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

/* bench/recycling_id_allocator_test.sv */
// ----------------------------------------------------------------------------
// recycling_id_allocator_test
// Self-checking bench for the recycling handle allocator. Requests go in as
// create, destroy and query transfers under random gaps and output stalls.
// An in-bench allocator tracks fresh handles, the recycle stack and slot
// occupancy to predict every response. The checker compares each response
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module recycling_id_allocator_test
    import rid_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // handles live in 1 .. TABLE_LIMIT-1
    localparam int TABLE_LIMIT = (CAPACITY_DEF < 256) ? CAPACITY_DEF : 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // predicted allocator state
    logic       slot_taken [TABLE_LIMIT];
    logic [7:0] recycled_ids [256];
    int         recycled_count;
    int         next_fresh;

    rsp_t expected_rsps[$];
    int   fail_count = 0;
    int   idle_cycles = 0;

    // traffic shaping knobs
    bit gaps_on = 1'b0;
    bit stalls_on = 1'b0;
    int burst_left = 0;
    int hold_off_req = 0;
    int stall_left = 0;

    recycling_id_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // allocator behavior, advances the predicted state by one request
    function automatic rsp_t predict_response(input req_t r);
        rsp_t       o;
        logic [7:0] id;
        logic       id_ok;
        id_ok = (r.handle != '0) && (int'(r.handle) < TABLE_LIMIT);
        o.result_handle = r.handle;
        o.status = ST_BAD;
        o.occupied = 1'b0;
        if (r.operation == OP_CREATE)
        begin
            if (recycled_count > 0)
            begin
                recycled_count--;
                id = recycled_ids[recycled_count];
            end
            else if (next_fresh < TABLE_LIMIT)
            begin
                id = next_fresh[7:0];
                next_fresh++;
            end
            else
            begin
                o.result_handle = '0;
                o.status = ST_FULL;
                return o;
            end
            slot_taken[id] = 1'b1;
            o.result_handle = id;
            o.status = ST_OK;
            o.occupied = 1'b1;
        end
        else if (r.operation == OP_DESTROY)
        begin
            if (id_ok && slot_taken[r.handle])
            begin
                slot_taken[r.handle] = 1'b0;
                if (recycled_count < TABLE_LIMIT && recycled_count < 256)
                begin
                    recycled_ids[recycled_count] = r.handle;
                    recycled_count++;
                end
                o.status = ST_OK;
            end
        end
        else if (id_ok && slot_taken[r.handle])
        begin
            // query, and the unused code behaves the same
            o.status = ST_OK;
            o.occupied = 1'b1;
        end
        return o;
    endfunction

    // random handle among the occupied slots, zero when none is occupied
    function automatic logic [7:0] pick_taken_id();
        logic [7:0] ids[$];
        for (int i = 1; i < TABLE_LIMIT; i++)
            if (slot_taken[i])
                ids.push_back(i[7:0]);
        if (ids.size() == 0)
            return 8'd0;
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // one request transfer, valid stays up afterwards for a following item
    task automatic send_request(input logic [1:0] op, input logic [7:0] id);
        req_t item;
        int   gap;
        item.operation = op;
        item.handle = id;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 15);
                burst_left = $urandom_range(1, 20);
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        expected_rsps.push_back(predict_response(item));
    endtask

    // random request, mostly well formed, biased toward growth or release
    task automatic send_random_request(input bit grow);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (grow ? 60 : 20))
            send_request(OP_CREATE, 8'($urandom_range(0, 255)));
        else if (roll < (grow ? 85 : 80))
        begin
            if ($urandom_range(0, 99) < 85)
                send_request(OP_DESTROY, pick_taken_id());
            else
                send_request(OP_DESTROY, 8'($urandom_range(0, 255)));
        end
        else
        begin
            send_request(($urandom_range(0, 19) == 0) ? OP_UNUSED : OP_QUERY,
                         ($urandom_range(0, 1) == 1) ? pick_taken_id()
                                                     : 8'($urandom_range(0, 255)));
        end
    endtask

    // corner cases right after reset
    task automatic test_directed();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_request(OP_QUERY, 8'd0);
        send_request(OP_QUERY, 8'd255);
        send_request(OP_QUERY, 8'd1);
        send_request(OP_DESTROY, 8'd0);
        send_request(OP_DESTROY, 8'd255);
        send_request(OP_DESTROY, 8'd5);
        send_request(OP_CREATE, 8'd255);
        send_request(OP_CREATE, 8'd0);
        send_request(OP_CREATE, 8'd170);
        send_request(OP_QUERY, 8'd2);
        send_request(OP_UNUSED, 8'd2);
        send_request(OP_UNUSED, 8'd200);
        send_request(OP_DESTROY, 8'd2);
        send_request(OP_DESTROY, 8'd2);
        send_request(OP_QUERY, 8'd2);
        // freed handles come back last in, first out
        send_request(OP_CREATE, 8'd0);
        send_request(OP_DESTROY, 8'd1);
        send_request(OP_DESTROY, 8'd3);
        send_request(OP_CREATE, 8'd0);
        send_request(OP_CREATE, 8'd0);
        send_request(OP_CREATE, 8'd0);
        send_request(OP_QUERY, 8'd128);
        send_request(OP_DESTROY, 8'd128);
    endtask

    // use up every fresh handle, then hit the full table
    task automatic test_fill_to_full();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        while (recycled_count != 0 || next_fresh < TABLE_LIMIT)
            send_request(OP_CREATE, 8'($urandom_range(0, 255)));
        repeat (3) send_request(OP_CREATE, 8'($urandom_range(0, 255)));
        send_request(OP_QUERY, 8'd255);
        send_request(OP_DESTROY, pick_taken_id());
        send_request(OP_CREATE, 8'd0);
        send_request(OP_CREATE, 8'd0);
    endtask

    // free every slot in random order, filling the recycle stack
    task automatic test_release_all();
        gaps_on = 1'b0;
        stalls_on = 1'b1;
        while (pick_taken_id() != 8'd0)
            send_request(OP_DESTROY, pick_taken_id());
        send_request(OP_DESTROY, 8'd77);
        send_request(OP_QUERY, 8'd77);
    endtask

    // mixed traffic in growth and release phases
    task automatic test_random_churn();
        for (int n = 0; n < 300; n++)
        begin
            if (n % 50 == 0)
            begin
                gaps_on = 1'($urandom_range(0, 1));
                stalls_on = 1'($urandom_range(0, 1));
            end
            send_random_request(((n / 50) % 2) == 0);
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        hold_off_req = 300;
        repeat (40) send_random_request(1'($urandom_range(0, 1)));
    endtask

    // receiver stall pattern and long hold-off
    always @(posedge clk)
    begin
        if (hold_off_req != 0)
        begin
            stall_left = hold_off_req;
            hold_off_req = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // response checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected response: handle %0d status %0d occupied %0d",
                             rsp.result_handle, rsp.status, rsp.occupied);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.result_handle !== want.result_handle ||
                    rsp.status !== want.status || rsp.occupied !== want.occupied)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: handle %0d/%0d status %0d/%0d occupied %0d/%0d",
                                 want.result_handle, rsp.result_handle,
                                 want.status, rsp.status,
                                 want.occupied, rsp.occupied);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_LIMIT; i++)
            slot_taken[i] = 1'b0;
        recycled_count = 0;
        next_fresh = 1;

        // reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_to_full();
        test_release_all();
        test_random_churn();
        test_output_backpressure();

        // drain outstanding responses
        req_valid <= 1'b0;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
